FILE: design/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and codes for the CSV row and field parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FEND = 2'd1;
	localparam logic [1:0] KIND_REND = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [1:0] ERR_QUOTE_TAIL = 2'd0;
	localparam logic [1:0] ERR_OPEN_QUOTE = 2'd1;
	localparam logic [1:0] ERR_COUNT      = 2'd2;

	localparam logic [1:0] REG_SEP    = 2'd0;
	localparam logic [1:0] REG_CHECK  = 2'd1;
	localparam logic [1:0] REG_EXPECT = 2'd2;

	localparam logic [7:0] SEP_RESET = 8'd44;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [8:0] num;
		logic [1:0] err;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       any;
		logic       two;
		result_t    r0;
		result_t    r1;
	} step_out_t;

	typedef struct packed {
		logic [7:0] sep;
		logic       check_on;
		logic [8:0] expected;
	} cfg_t;

endpackage

FILE: design/csvp_regs.sv
// ----------------------------------------------------------------------------
// csvp_regs
// Configuration registers behind the APB port.
// ----------------------------------------------------------------------------
module csvp_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output csvp_pkg::cfg_t      cfg
);

	csvp_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep      <= csvp_pkg::SEP_RESET;
			cfg_q.check_on <= 1'b0;
			cfg_q.expected <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				csvp_pkg::REG_SEP:    cfg_q.sep      <= pwdata[7:0];
				csvp_pkg::REG_CHECK:  cfg_q.check_on <= pwdata[0];
				csvp_pkg::REG_EXPECT: cfg_q.expected <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			csvp_pkg::REG_SEP:    prdata = {24'd0, cfg_q.sep};
			csvp_pkg::REG_CHECK:  prdata = {31'd0, cfg_q.check_on};
			csvp_pkg::REG_EXPECT: prdata = {23'd0, cfg_q.expected};
			default:              prdata = '0;
		endcase
	end

endmodule

FILE: design/csvp_step.sv
// ----------------------------------------------------------------------------
// csvp_step
// Parse state machine: one byte in, up to two results out per step.
// ----------------------------------------------------------------------------
module csvp_step #(
	parameter int MAX_FIELDS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_input,
	input  csvp_pkg::cfg_t       cfg,
	output csvp_pkg::step_out_t  so
);

	localparam logic [8:0] LIMIT = (MAX_FIELDS < 511) ? 9'(MAX_FIELDS) : 9'd511;

	typedef enum logic [2:0] {
		M_ROW, M_FSTART, M_PLAIN, M_QUOTED, M_QSEEN, M_SKIP, M_AFTCR
	} mode_t;

	mode_t      mode_q, nm, m, eol_mode;
	logic [8:0] cnt_q, nc, c;
	logic       done, eol, is_quote, is_sep, is_ws;

	function automatic csvp_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] data,
			input logic [8:0] num, input logic [1:0] err);
		csvp_pkg::result_t r;
		r.kind = kind;
		r.data = data;
		r.num  = num;
		r.err  = err;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [8:0] inc(input logic [8:0] v);
		return (v < LIMIT) ? v + 9'd1 : v;
	endfunction

	function automatic csvp_pkg::result_t row_res(input logic [8:0] v, input csvp_pkg::cfg_t cf);
		if (cf.check_on && v != cf.expected)
			return mk(csvp_pkg::KIND_ERR, 8'd0, v, csvp_pkg::ERR_COUNT);
		return mk(csvp_pkg::KIND_REND, 8'd0, v, 2'd0);
	endfunction

	assign eol      = (in_byte == csvp_pkg::CH_LF) || (in_byte == csvp_pkg::CH_CR);
	assign is_quote = (in_byte == csvp_pkg::CH_QUOTE);
	assign is_sep   = (in_byte == cfg.sep);
	assign is_ws    = (in_byte == csvp_pkg::CH_SPACE) || (in_byte == csvp_pkg::CH_TAB);
	assign eol_mode = (in_byte == csvp_pkg::CH_CR) ? M_AFTCR : M_ROW;

	always_comb begin
		so   = '0;
		nm   = mode_q;
		nc   = cnt_q;
		c    = cnt_q;
		m    = (mode_q > M_AFTCR) ? M_ROW : mode_q;
		done = 1'b0;
		if (end_of_input) begin
			nm = M_ROW;
			nc = '0;
			if (m == M_FSTART || m == M_PLAIN || m == M_QSEEN) begin
				so.any = 1'b1;
				so.two = 1'b1;
				so.r0  = mk(csvp_pkg::KIND_FEND, 8'd0, c, 2'd0);
				so.r1  = row_res(inc(c), cfg);
			end else if (m == M_QUOTED) begin
				so.any = 1'b1;
				so.r0  = mk(csvp_pkg::KIND_ERR, 8'd0, c, csvp_pkg::ERR_OPEN_QUOTE);
			end
		end else begin
			if (m == M_AFTCR) begin
				m    = M_ROW;
				nm   = M_ROW;
				done = (in_byte == csvp_pkg::CH_LF);
			end
			if (!done && m == M_ROW) begin
				c  = '0;
				nc = '0;
				if (is_ws) begin
					done = 1'b1;
				end else if (eol) begin
					so.any = 1'b1;
					so.r0  = row_res(9'd0, cfg);
					nm     = eol_mode;
					done   = 1'b1;
				end else begin
					m = M_FSTART;
				end
			end
			if (!done) begin
				unique case (m)
					M_FSTART, M_PLAIN: begin
						if (is_quote && m == M_FSTART) begin
							nm = M_QUOTED;
						end else if (is_quote) begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_DATA, in_byte, c, 2'd0);
							nm     = M_PLAIN;
						end else if (is_sep) begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_FEND, 8'd0, c, 2'd0);
							nc     = inc(c);
							nm     = M_FSTART;
						end else if (eol) begin
							so.any = 1'b1;
							so.two = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_FEND, 8'd0, c, 2'd0);
							so.r1  = row_res(inc(c), cfg);
							nc     = '0;
							nm     = eol_mode;
						end else begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_DATA, in_byte, c, 2'd0);
							nm     = M_PLAIN;
						end
					end
					M_QUOTED: begin
						if (is_quote) begin
							nm = M_QSEEN;
						end else begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_DATA, in_byte, c, 2'd0);
							nm     = M_QUOTED;
						end
					end
					M_QSEEN: begin
						if (is_quote) begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_DATA, in_byte, c, 2'd0);
							nm     = M_QUOTED;
						end else if (is_sep) begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_FEND, 8'd0, c, 2'd0);
							nc     = inc(c);
							nm     = M_FSTART;
						end else if (eol) begin
							so.any = 1'b1;
							so.two = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_FEND, 8'd0, c, 2'd0);
							so.r1  = row_res(inc(c), cfg);
							nc     = '0;
							nm     = eol_mode;
						end else begin
							so.any = 1'b1;
							so.r0  = mk(csvp_pkg::KIND_ERR, 8'd0, c, csvp_pkg::ERR_QUOTE_TAIL);
							nm     = M_SKIP;
						end
					end
					M_SKIP: begin
						if (eol) begin
							nm = eol_mode;
							nc = '0;
						end
					end
					default: ;
				endcase
			end
		end
		so.r0.last = ~so.two;
		so.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_ROW;
			cnt_q  <= '0;
		end else if (advance) begin
			mode_q <= nm;
			cnt_q  <= nc;
		end
	end

endmodule

FILE: design/csvp_outq.sv
// ----------------------------------------------------------------------------
// csvp_outq
// Two-entry result queue; an entry holding two results drains in two beats.
// ----------------------------------------------------------------------------
module csvp_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  csvp_pkg::step_out_t  push_entry,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output csvp_pkg::result_t    res
);

	csvp_pkg::step_out_t entry_q [2];
	logic                wr_q, rd_q, sub_q;
	logic [1:0]          cnt_q;
	logic                beat, pop;
	csvp_pkg::step_out_t head;

	assign head      = entry_q[rd_q];
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign res       = sub_q ? head.r1 : head.r0;
	assign beat      = out_valid & ~out_stall;
	assign pop       = beat & (sub_q | ~head.two);

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			sub_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (beat)
				sub_q <= ~pop;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: design/csv_row_field_parser_core.sv
// ----------------------------------------------------------------------------
// csv_row_field_parser_core
// Streaming CSV splitter: bytes in, data / field-end / row-end / error out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result queue is not full. An accepted
// byte is registered, parsed from that register and its results are written
// into a two-entry result queue whose head drives the output port. Most
// bytes give zero or one result; a line end (or end of input) that closes a
// field gives a field end and a row end (or count error), which leave in two
// output beats, and a sustained run of such bytes is paced by the single
// output port. Input stall rises only when the result queue is full.
// Configuration must be written while no item is in flight.
module csv_row_field_parser_core #(
	parameter int MAX_FIELDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  item_kind,
	output logic [7:0]  out_byte,
	output logic [8:0]  field_number,
	output logic [1:0]  error_code,
	output logic        last
);

	csvp_pkg::cfg_t      cfg;
	csvp_pkg::step_out_t so;
	csvp_pkg::result_t   res;
	logic                valid_s1, eoi_s1, full, advance;
	logic [7:0]          byte_s1;

	csvp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = valid_s1 & full;
	assign advance  = valid_s1 & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	csvp_step #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.cfg          (cfg),
		.so           (so)
	);

	csvp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance & so.any),
		.push_entry (so),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign item_kind    = res.kind;
	assign out_byte     = res.data;
	assign field_number = res.num;
	assign error_code   = res.err;
	assign last         = res.last;

endmodule

FILE: design/csvp_check.sv
// ----------------------------------------------------------------------------
// csvp_check
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module csvp_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] item_kind,
	input logic [7:0] out_byte,
	input logic [8:0] field_number,
	input logic [1:0] error_code,
	input logic       last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable({item_kind, out_byte, field_number, error_code, last}))
		else $error("result beat changed while stalled");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != csvp_pkg::KIND_ERR |-> error_code == 2'd0)
		else $error("error code set on non-error result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != csvp_pkg::KIND_DATA |-> out_byte == 8'd0)
		else $error("byte set on non-data result");

	a_row_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == csvp_pkg::KIND_REND || item_kind == csvp_pkg::KIND_ERR)
			|-> last)
		else $error("row end or error not last of its byte");

endmodule

bind csv_row_field_parser_core csvp_check u_check (.*);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks csv_row_field_parser_core against a cycle-free scan predictor. Text
// beats come from a queue through a clocked driver with random gaps; output
// beats are compared field by field in a clocked monitor while the receiver
// stalls at random. Phases change separator, count check and expected field
// count between runs of directed and randomly shaped CSV rows.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_FIELDS = 256;
	localparam int FIELD_CAP = (MAX_FIELDS < 511) ? MAX_FIELDS : 511;
	localparam int HALF_PERIOD = 5;
	localparam int SETTLE = 8;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AT = 60;
	localparam int STALL_LIMIT = 4000;
	localparam int PRINT_CAP = 40;
	localparam logic [1:0] NO_ERR = 2'd0;

	typedef enum logic [2:0] {
		AT_ROW, AT_FIELD, IN_PLAIN, IN_QUOTES, QUOTE_SEEN, DROPPING, AFTER_CR
	} scan_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} text_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  item_kind;
	logic [7:0]  out_byte;
	logic [8:0]  field_number;
	logic [1:0]  error_code;
	logic        last;

	csv_row_field_parser_core #(.MAX_FIELDS(MAX_FIELDS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall), .item_kind(item_kind),
		.out_byte(out_byte), .field_number(field_number), .error_code(error_code),
		.last(last)
	);

	always #HALF_PERIOD clk = ~clk;

	text_beat_t        text_q[$];
	csvp_pkg::result_t expected_tokens[$];

	logic [7:0] cfg_sep = csvp_pkg::SEP_RESET;
	logic       cfg_check = 1'b0;
	logic [8:0] cfg_expect = '0;
	scan_t      scan = AT_ROW;
	logic [8:0] nfields = '0;

	csvp_pkg::result_t step_buf[3];
	int                step_cnt;

	int  err_count = 0;
	int  bytes_in = 0;
	int  tokens_out = 0;
	int  rows_seen = 0;
	int  errs_seen = 0;
	int  pushed = 0;
	int  settings = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  idle_cycles = 0;
	logic calm = 1'b0;
	logic hold_done = 1'b0;

	// ---------------- scan predictor ----------------
	task automatic add_token(input logic [1:0] kind, input logic [7:0] data,
			input logic [8:0] num, input logic [1:0] err);
		step_buf[step_cnt] = '{kind: kind, data: data, num: num, err: err, last: 1'b0};
		step_cnt++;
	endtask

	task automatic close_field();
		add_token(csvp_pkg::KIND_FEND, 8'd0, nfields, NO_ERR);
		if (nfields < FIELD_CAP)
			nfields++;
	endtask

	task automatic end_line(input logic [7:0] b);
		if (cfg_check && nfields != cfg_expect)
			add_token(csvp_pkg::KIND_ERR, 8'd0, nfields, csvp_pkg::ERR_COUNT);
		else
			add_token(csvp_pkg::KIND_REND, 8'd0, nfields, NO_ERR);
		nfields = '0;
		scan = (b == csvp_pkg::CH_CR) ? AFTER_CR : AT_ROW;
	endtask

	task automatic split_byte(input logic [7:0] b, input logic eoi);
		scan_t             m;
		logic              eol;
		logic              done;
		csvp_pkg::result_t t;
		m = scan;
		eol = (b == csvp_pkg::CH_LF) || (b == csvp_pkg::CH_CR);
		done = 1'b0;
		step_cnt = 0;
		if (eoi) begin
			if (m == AT_FIELD || m == IN_PLAIN || m == QUOTE_SEEN) begin
				close_field();
				end_line(csvp_pkg::CH_LF);
			end else if (m == IN_QUOTES) begin
				add_token(csvp_pkg::KIND_ERR, 8'd0, nfields, csvp_pkg::ERR_OPEN_QUOTE);
			end
			scan = AT_ROW;
			nfields = '0;
		end else begin
			if (m == AFTER_CR) begin
				m = AT_ROW;
				scan = AT_ROW;
				done = (b == csvp_pkg::CH_LF);
			end
			if (!done && m == AT_ROW) begin
				nfields = '0;
				if (b == csvp_pkg::CH_SPACE || b == csvp_pkg::CH_TAB) begin
					done = 1'b1;
				end else if (eol) begin
					end_line(b);
					done = 1'b1;
				end else begin
					m = AT_FIELD;
				end
			end
			if (!done) begin
				case (m)
					AT_FIELD, IN_PLAIN: begin
						if (b == csvp_pkg::CH_QUOTE && m == AT_FIELD) begin
							scan = IN_QUOTES;
						end else if (b == csvp_pkg::CH_QUOTE) begin
							add_token(csvp_pkg::KIND_DATA, b, nfields, NO_ERR);
							scan = IN_PLAIN;
						end else if (b == cfg_sep) begin
							close_field();
							scan = AT_FIELD;
						end else if (eol) begin
							close_field();
							end_line(b);
						end else begin
							add_token(csvp_pkg::KIND_DATA, b, nfields, NO_ERR);
							scan = IN_PLAIN;
						end
					end
					IN_QUOTES: begin
						if (b == csvp_pkg::CH_QUOTE)
							scan = QUOTE_SEEN;
						else
							add_token(csvp_pkg::KIND_DATA, b, nfields, NO_ERR);
					end
					QUOTE_SEEN: begin
						if (b == csvp_pkg::CH_QUOTE) begin
							add_token(csvp_pkg::KIND_DATA, b, nfields, NO_ERR);
							scan = IN_QUOTES;
						end else if (b == cfg_sep) begin
							close_field();
							scan = AT_FIELD;
						end else if (eol) begin
							close_field();
							end_line(b);
						end else begin
							add_token(csvp_pkg::KIND_ERR, 8'd0, nfields,
								csvp_pkg::ERR_QUOTE_TAIL);
							scan = DROPPING;
						end
					end
					default: begin
						if (eol) begin
							scan = (b == csvp_pkg::CH_CR) ? AFTER_CR : AT_ROW;
							nfields = '0;
						end
					end
				endcase
			end
		end
		for (int i = 0; i < step_cnt; i++) begin
			t = step_buf[i];
			t.last = (i == step_cnt - 1);
			expected_tokens.push_back(t);
		end
	endtask

	// ---------------- checking ----------------
	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < PRINT_CAP)
			$display("MISMATCH @%0t beat %0d %s: got %0d want %0d",
				$realtime, tokens_out, what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin : watch_out
		csvp_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			tokens_out++;
			if (item_kind == csvp_pkg::KIND_REND)
				rows_seen++;
			if (item_kind == csvp_pkg::KIND_ERR)
				errs_seen++;
			if (expected_tokens.size() == 0) begin
				report_mismatch("unexpected beat, kind", item_kind, -1);
			end else begin
				want = expected_tokens.pop_front();
				if (item_kind !== want.kind)
					report_mismatch("item_kind", item_kind, want.kind);
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
				if (field_number !== want.num)
					report_mismatch("field_number", field_number, want.num);
				if (error_code !== want.err)
					report_mismatch("error_code", error_code, want.err);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin : drive_text
		text_beat_t beat;
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= '0;
			end_of_input <= 1'b0;
			gap_left = 0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				split_byte(in_byte, end_of_input);
				bytes_in++;
				nv = 1'b0;
				if (!calm && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 18);
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (text_q.size() > 0) begin
					beat = text_q.pop_front();
					in_byte <= beat.b;
					end_of_input <= beat.eoi;
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	// receiver stalls; one long hold-off early on lets the block back up
	always @(posedge clk or negedge arst_n) begin : drive_stall
		logic ns;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			ns = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else if (!hold_done && bytes_in >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				ns = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				ns = 1'b1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				ns = 1'b1;
			end
			out_stall <= ns;
		end
	end

	// ---------------- stimulus ----------------
	task automatic push_item(input logic [7:0] b, input logic eoi);
		text_q.push_back('{b: b, eoi: eoi});
		pushed++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(8'(s[i]), 1'b0);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		if (c == cfg_sep || c == csvp_pkg::CH_QUOTE)
			c = "a";
		return c;
	endfunction

	task automatic push_row();
		int nf;
		int len;
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				push_item($urandom_range(0, 1) ? csvp_pkg::CH_SPACE : csvp_pkg::CH_TAB,
					1'b0);
		if (cfg_check && cfg_expect <= 6 && $urandom_range(0, 3) != 0)
			nf = cfg_expect;
		else
			nf = $urandom_range(0, 4);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				push_item(cfg_sep, 1'b0);
			len = $urandom_range(0, 3);
			if ($urandom_range(0, 2) == 0) begin
				push_item(csvp_pkg::CH_QUOTE, 1'b0);
				for (int j = 0; j < len; j++) begin
					c = 8'($urandom_range(0, 255));
					push_item(c, 1'b0);
					if (c == csvp_pkg::CH_QUOTE)
						push_item(c, 1'b0);
				end
				push_item(csvp_pkg::CH_QUOTE, 1'b0);
			end else begin
				for (int j = 0; j < len; j++) begin
					c = plain_byte();
					if (j > 0 && $urandom_range(0, 7) == 0)
						c = csvp_pkg::CH_QUOTE;
					push_item(c, 1'b0);
				end
			end
		end
		case ($urandom_range(0, 3))
			0: push_item(csvp_pkg::CH_LF, 1'b0);
			1: push_item(csvp_pkg::CH_CR, 1'b0);
			2: begin
				push_item(csvp_pkg::CH_CR, 1'b0);
				push_item(csvp_pkg::CH_LF, 1'b0);
			end
			default: push_item(8'($urandom_range(0, 255)), 1'b1);
		endcase
	endtask

	task automatic push_random(input int n);
		int start;
		int pick;
		start = pushed;
		while (pushed - start < n) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				push_row();
			end else if (pick == 7) begin
				repeat ($urandom_range(1, 4))
					push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else if (pick == 8) begin
				push_item(csvp_pkg::CH_QUOTE, 1'b0);
				push_item(plain_byte(), 1'b0);
				push_item(csvp_pkg::CH_QUOTE, 1'b0);
				push_item(plain_byte(), 1'b0);
				repeat ($urandom_range(0, 3))
					push_item(8'($urandom_range(0, 255)), 1'b0);
				push_item(csvp_pkg::CH_LF, 1'b0);
			end else begin
				push_item(8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_dialect(input logic [7:0] sep, input logic chk, input logic [8:0] cnt);
		apb_write(csvp_pkg::REG_SEP, {24'd0, sep});
		apb_write(csvp_pkg::REG_CHECK, {31'd0, chk});
		apb_write(csvp_pkg::REG_EXPECT, {23'd0, cnt});
		cfg_sep = sep;
		cfg_check = chk;
		cfg_expect = cnt;
		settings++;
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (text_q.size() != 0 || in_valid || expected_tokens.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_dialect(",", 1'b0, 9'd0);
		push_text(" \t\",\"\"\",");
		push_item(8'hFF, 1'b0);
		push_item(csvp_pkg::CH_QUOTE, 1'b0);
		push_item(8'h00, 1'b0);
		push_text("\r\n\n\"x\"y");
		push_item(8'h00, 1'b1);
		push_text("a,");
		push_item(8'h7F, 1'b1);
		push_text("\"q");
		push_item(8'hA5, 1'b1);
		push_item(8'h00, 1'b1);
		push_text("\r");
		push_item(8'hFF, 1'b1);
		push_random(50);
		wait_quiet();

		set_dialect(8'h00, 1'b1, 9'd3);
		push_random(40);
		wait_quiet();

		// a row of empty fields split by a high separator byte
		set_dialect(8'hFF, 1'b1, 9'd13);
		repeat (12) push_item(8'hFF, 1'b0);
		push_item(csvp_pkg::CH_LF, 1'b0);
		push_random(30);
		wait_quiet();

		set_dialect(csvp_pkg::CH_SPACE, 1'b0, 9'd0);
		push_random(30);
		wait_quiet();

		set_dialect(csvp_pkg::CH_QUOTE, 1'b1, 9'd0);
		push_random(25);
		wait_quiet();

		set_dialect(csvp_pkg::CH_CR, 1'b0, 9'd2);
		push_random(25);
		wait_quiet();

		calm = 1'b1;
		set_dialect(",", 1'b1, 9'd2);
		push_random(30);
		wait_quiet();

		$display("Ran %0d text beats through %0d separator/count settings", bytes_in, settings);
		$display("Checked %0d output beats: %0d row ends, %0d error beats",
			tokens_out, rows_seen, errs_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
